// ===== sv/phlm_pkg.sv =====
package phlm_pkg;

    localparam int CHANNELS   = 8;
    localparam int CH_BITS    = 3;
    localparam int LEVEL_BITS = 16;
    localparam int WIDTH_BITS = 8;
    localparam int OVER_BITS  = 32;
    localparam int CLIP_BITS  = 9;
    localparam int ZONE_BITS  = 2;
    localparam int Q_DEPTH    = 4;
    localparam int Q_BITS     = 2;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] REG_METER_WIDTH = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_AMBER_LEVEL = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_RED_LEVEL   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_HOLD_TICKS  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_DECAY_STEP  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_OVER_RUN    = 3'd5;

    localparam logic [ZONE_BITS-1:0] ZONE_NORMAL = 2'd0;
    localparam logic [ZONE_BITS-1:0] ZONE_AMBER  = 2'd1;
    localparam logic [ZONE_BITS-1:0] ZONE_RED    = 2'd2;

    typedef struct packed {
        logic [WIDTH_BITS-1:0] meter_width;
        logic [LEVEL_BITS-1:0] amber_level;
        logic [LEVEL_BITS-1:0] red_level;
        logic [WIDTH_BITS-1:0] hold_ticks;
        logic [LEVEL_BITS-1:0] decay_step;
        logic [WIDTH_BITS-1:0] over_run;
    } cfg_t;

    // One accepted measurement, tagged with its clip class by the front end.
    typedef struct packed {
        logic [CH_BITS-1:0]    chan;
        logic [LEVEL_BITS-1:0] peak;
        logic [LEVEL_BITS-1:0] rms;
        logic                  clip;
    } item_t;

    // Channel state as seen by the result, handed to the scaling stage.
    typedef struct packed {
        logic [CH_BITS-1:0]    chan;
        logic [LEVEL_BITS-1:0] peak;
        logic [LEVEL_BITS-1:0] rms;
        logic [LEVEL_BITS-1:0] hold;
        logic                  clip_flag;
        logic [OVER_BITS-1:0]  over;
    } meas_t;

    typedef struct packed {
        logic [CH_BITS-1:0]    chan;
        logic [WIDTH_BITS-1:0] peak_seg;
        logic [WIDTH_BITS-1:0] rms_seg;
        logic [WIDTH_BITS-1:0] hold_pos;
        logic [ZONE_BITS-1:0]  peak_zone;
        logic [ZONE_BITS-1:0]  hold_zone;
        logic                  clip_flag;
        logic [OVER_BITS-1:0]  over;
    } res_t;

endpackage

// ===== sv/phlm_front.sv =====
module phlm_front
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic [phlm_pkg::CH_BITS-1:0]       channel,
    input  logic [phlm_pkg::LEVEL_BITS-1:0]    peak_level,
    input  logic [phlm_pkg::LEVEL_BITS-1:0]    rms_level,
    output logic                               head_valid,
    output phlm_pkg::item_t                    head,
    input  logic                               head_pop
);

    phlm_pkg::item_t                  q_reg [phlm_pkg::Q_DEPTH];
    logic [phlm_pkg::Q_BITS-1:0]      wr_ptr_reg;
    logic [phlm_pkg::Q_BITS-1:0]      rd_ptr_reg;
    logic [phlm_pkg::Q_BITS:0]        count_reg;
    logic [phlm_pkg::Q_BITS:0]        count_next;
    logic                             do_push;
    logic                             do_pop;
    phlm_pkg::item_t                  new_item;

    assign full       = (count_reg == (phlm_pkg::Q_BITS+1)'(phlm_pkg::Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = q_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = head_pop && head_valid;

    // A peak at or above full scale has its top bit set.
    always_comb
    begin
        new_item.chan = channel;
        new_item.peak = peak_level;
        new_item.rms  = rms_level;
        new_item.clip = peak_level[phlm_pkg::LEVEL_BITS-1];
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

// ===== sv/phlm_track.sv =====
module phlm_track
(
    input  logic              clk,
    input  logic              rst_n,
    input  phlm_pkg::cfg_t    cfg,
    input  logic              head_valid,
    input  phlm_pkg::item_t   head,
    output logic              head_pop,
    input  logic              meas_ready,
    output logic              meas_valid,
    output phlm_pkg::meas_t   meas
);

    logic [phlm_pkg::WIDTH_BITS-1:0] hold_count_reg [phlm_pkg::CHANNELS];
    logic [phlm_pkg::CLIP_BITS-1:0]  clip_count_reg [phlm_pkg::CHANNELS];
    logic [phlm_pkg::LEVEL_BITS-1:0] peak_hold_reg  [phlm_pkg::CHANNELS];
    logic [phlm_pkg::WIDTH_BITS-1:0] run_count_reg  [phlm_pkg::CHANNELS];
    logic [phlm_pkg::OVER_BITS-1:0]  over_total_reg [phlm_pkg::CHANNELS];

    logic [phlm_pkg::CH_BITS-1:0]    row;
    logic                            fire;
    logic [phlm_pkg::WIDTH_BITS-1:0] run_next;
    logic [phlm_pkg::CLIP_BITS-1:0]  clip_armed;
    logic [phlm_pkg::CLIP_BITS-1:0]  clip_next;
    logic [phlm_pkg::OVER_BITS-1:0]  over_next;
    logic                            raise;
    logic [phlm_pkg::LEVEL_BITS-1:0] hold_raised;
    logic [phlm_pkg::WIDTH_BITS-1:0] count_raised;
    logic [phlm_pkg::LEVEL_BITS-1:0] hold_next;
    logic [phlm_pkg::WIDTH_BITS-1:0] count_next;

    assign row        = head.chan;
    assign fire       = head_valid && meas_ready;
    assign head_pop   = fire;
    assign meas_valid = fire;

    always_comb
    begin
        if (head.clip)
        begin
            run_next   = (&run_count_reg[row]) ? run_count_reg[row]
                                               : run_count_reg[row] + 1'b1;
            clip_armed = {cfg.hold_ticks, 1'b0};
        end
        else
        begin
            run_next   = '0;
            clip_armed = clip_count_reg[row];
        end

        over_next = over_total_reg[row];
        if (head.clip && (run_next >= cfg.over_run) && !(&over_total_reg[row]))
        begin
            over_next = over_total_reg[row] + 1'b1;
        end

        raise        = peak_hold_reg[row] < head.peak;
        hold_raised  = raise ? head.peak : peak_hold_reg[row];
        count_raised = raise ? cfg.hold_ticks : hold_count_reg[row];

        // The hold timer runs out first; only then does the held value decay.
        if (count_raised != '0)
        begin
            count_next = count_raised - 1'b1;
            hold_next  = hold_raised;
        end
        else
        begin
            count_next = count_raised;
            hold_next  = (hold_raised >= cfg.decay_step) ? hold_raised - cfg.decay_step
                                                         : '0;
        end

        clip_next = (clip_armed != '0) ? clip_armed - 1'b1 : clip_armed;

        meas.chan      = head.chan;
        meas.peak      = head.peak;
        meas.rms       = head.rms;
        meas.hold      = hold_raised;
        meas.clip_flag = (clip_armed != '0);
        meas.over      = over_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < phlm_pkg::CHANNELS; i++)
            begin
                hold_count_reg[i] <= '0;
                clip_count_reg[i] <= '0;
                peak_hold_reg[i]  <= '0;
                run_count_reg[i]  <= '0;
                over_total_reg[i] <= '0;
            end
        end
        else if (fire)
        begin
            hold_count_reg[row] <= count_next;
            clip_count_reg[row] <= clip_next;
            peak_hold_reg[row]  <= hold_next;
            run_count_reg[row]  <= run_next;
            over_total_reg[row] <= over_next;
        end
    end

endmodule

// ===== sv/phlm_scale.sv =====
module phlm_scale
(
    input  logic              clk,
    input  logic              rst_n,
    input  phlm_pkg::cfg_t    cfg,
    input  logic              meas_valid,
    input  phlm_pkg::meas_t   meas,
    output logic              meas_ready,
    output logic              res_valid,
    output phlm_pkg::res_t    res,
    input  logic              res_pop
);

    localparam int PROD_BITS = phlm_pkg::LEVEL_BITS + phlm_pkg::WIDTH_BITS;
    localparam int SEG_BITS  = phlm_pkg::WIDTH_BITS + 1;

    phlm_pkg::meas_t                  s2_reg;
    logic                             s2_valid_reg;
    phlm_pkg::res_t                   q_reg [phlm_pkg::Q_DEPTH];
    logic [phlm_pkg::Q_BITS-1:0]      wr_ptr_reg;
    logic [phlm_pkg::Q_BITS-1:0]      rd_ptr_reg;
    logic [phlm_pkg::Q_BITS:0]        count_reg;
    logic [phlm_pkg::Q_BITS:0]        count_next;
    logic                             q_full;
    logic                             do_push;
    logic                             do_pop;
    phlm_pkg::res_t                   res_next;
    logic [PROD_BITS-1:0]             peak_prod;
    logic [PROD_BITS-1:0]             rms_prod;
    logic [PROD_BITS-1:0]             hold_prod;
    logic [SEG_BITS-1:0]              hold_raw;
    logic [SEG_BITS-1:0]              hold_less;
    logic [SEG_BITS-1:0]              width_ext;

    function automatic logic [phlm_pkg::WIDTH_BITS-1:0] clamp_seg(
        input logic [SEG_BITS-1:0]             s,
        input logic [phlm_pkg::WIDTH_BITS-1:0] mw
    );
        logic [SEG_BITS-1:0] mw_ext;
        mw_ext = {1'b0, mw};
        return (s > mw_ext) ? mw : s[phlm_pkg::WIDTH_BITS-1:0];
    endfunction

    function automatic logic [phlm_pkg::ZONE_BITS-1:0] zone_of(
        input logic [phlm_pkg::LEVEL_BITS-1:0] level,
        input phlm_pkg::cfg_t                  c
    );
        logic [phlm_pkg::ZONE_BITS-1:0] z;
        priority if (level >= c.red_level)
        begin
            z = phlm_pkg::ZONE_RED;
        end
        else if (level >= c.amber_level)
        begin
            z = phlm_pkg::ZONE_AMBER;
        end
        else
        begin
            z = phlm_pkg::ZONE_NORMAL;
        end
        return z;
    endfunction

    assign q_full     = (count_reg == (phlm_pkg::Q_BITS+1)'(phlm_pkg::Q_DEPTH));
    assign do_push    = s2_valid_reg && !q_full;
    assign do_pop     = res_pop && res_valid;
    assign meas_ready = !s2_valid_reg || do_push;
    assign res_valid  = (count_reg != '0);
    assign res        = q_reg[rd_ptr_reg];

    // Segment count is width * level / full scale, full scale being 2^(LEVEL_BITS-1).
    always_comb
    begin
        width_ext = {1'b0, cfg.meter_width};
        peak_prod = PROD_BITS'(cfg.meter_width) * PROD_BITS'(s2_reg.peak);
        rms_prod  = PROD_BITS'(cfg.meter_width) * PROD_BITS'(s2_reg.rms);
        hold_prod = PROD_BITS'(cfg.meter_width) * PROD_BITS'(s2_reg.hold);
        hold_raw  = hold_prod[PROD_BITS-1:phlm_pkg::LEVEL_BITS-1];
        hold_less = (hold_raw < SEG_BITS'(2)) ? '0 : hold_raw - SEG_BITS'(2);

        res_next.chan      = s2_reg.chan;
        res_next.peak_seg  = clamp_seg(peak_prod[PROD_BITS-1:phlm_pkg::LEVEL_BITS-1],
                                       cfg.meter_width);
        res_next.rms_seg   = clamp_seg(rms_prod[PROD_BITS-1:phlm_pkg::LEVEL_BITS-1],
                                       cfg.meter_width);
        res_next.hold_pos  = (hold_less > width_ext) ? cfg.meter_width
                                                     : hold_less[phlm_pkg::WIDTH_BITS-1:0];
        res_next.peak_zone = zone_of(s2_reg.peak, cfg);
        res_next.hold_zone = zone_of(s2_reg.hold, cfg);
        res_next.clip_flag = s2_reg.clip_flag;
        res_next.over      = s2_reg.over;
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (meas_ready)
            begin
                s2_valid_reg <= meas_valid;
            end
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (meas_ready && meas_valid)
        begin
            s2_reg <= meas;
        end
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= res_next;
        end
    end

endmodule

// ===== sv/peak_hold_level_meter.sv =====
// A word accepted at the ports passes the input queue, the channel state update and
// scaling into the result queue before it shows on the result ports.
// Throughput: one word per cycle unless back-pressured; channel state is read, updated
// and written in the same cycle, so back-to-back words on one channel never stall.
// Reset clears both queues, all per-channel state and loads the register defaults.
module peak_hold_level_meter
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic [phlm_pkg::CH_BITS-1:0]          channel,
    input  logic [phlm_pkg::LEVEL_BITS-1:0]       peak_level,
    input  logic [phlm_pkg::LEVEL_BITS-1:0]       rms_level,
    output logic                                  empty,
    input  logic                                  pop,
    output logic [phlm_pkg::CH_BITS-1:0]          out_channel,
    output logic [phlm_pkg::WIDTH_BITS-1:0]       peak_segments,
    output logic [phlm_pkg::WIDTH_BITS-1:0]       rms_segments,
    output logic [phlm_pkg::WIDTH_BITS-1:0]       hold_position,
    output logic [phlm_pkg::ZONE_BITS-1:0]        peak_zone,
    output logic [phlm_pkg::ZONE_BITS-1:0]        hold_zone,
    output logic                                  clip_flag,
    output logic [phlm_pkg::OVER_BITS-1:0]        over_count,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [phlm_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [phlm_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    phlm_pkg::cfg_t   cfg_reg;
    logic             head_valid;
    phlm_pkg::item_t  head;
    logic             head_pop;
    logic             meas_valid;
    logic             meas_ready;
    phlm_pkg::meas_t  meas;
    logic             res_valid;
    phlm_pkg::res_t   res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.meter_width <= 8'd38;
            cfg_reg.amber_level <= 16'd21955;
            cfg_reg.red_level   <= 16'd25887;
            cfg_reg.hold_ticks  <= 8'd24;
            cfg_reg.decay_step  <= 16'd655;
            cfg_reg.over_run    <= 8'd3;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                phlm_pkg::REG_METER_WIDTH: cfg_reg.meter_width <= cfg_data[7:0];
                phlm_pkg::REG_AMBER_LEVEL: cfg_reg.amber_level <= cfg_data;
                phlm_pkg::REG_RED_LEVEL:   cfg_reg.red_level   <= cfg_data;
                phlm_pkg::REG_HOLD_TICKS:  cfg_reg.hold_ticks  <= cfg_data[7:0];
                phlm_pkg::REG_DECAY_STEP:  cfg_reg.decay_step  <= cfg_data;
                phlm_pkg::REG_OVER_RUN:    cfg_reg.over_run    <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    phlm_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .channel    (channel),
        .peak_level (peak_level),
        .rms_level  (rms_level),
        .head_valid (head_valid),
        .head       (head),
        .head_pop   (head_pop)
    );

    phlm_track u_track
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head       (head),
        .head_pop   (head_pop),
        .meas_ready (meas_ready),
        .meas_valid (meas_valid),
        .meas       (meas)
    );

    phlm_scale u_scale
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .meas_valid (meas_valid),
        .meas       (meas),
        .meas_ready (meas_ready),
        .res_valid  (res_valid),
        .res        (res),
        .res_pop    (pop)
    );

    assign empty         = !res_valid;
    assign out_channel   = res.chan;
    assign peak_segments = res.peak_seg;
    assign rms_segments  = res.rms_seg;
    assign hold_position = res.hold_pos;
    assign peak_zone     = res.peak_zone;
    assign hold_zone     = res.hold_zone;
    assign clip_flag     = res.clip_flag;
    assign over_count    = res.over;

endmodule

// ===== sv/phlm_checker.sv =====
module phlm_checker
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  empty,
    input  logic                                  pop,
    input  logic [phlm_pkg::CH_BITS-1:0]          out_channel,
    input  logic [phlm_pkg::WIDTH_BITS-1:0]       peak_segments,
    input  logic [phlm_pkg::ZONE_BITS-1:0]        peak_zone,
    input  logic [phlm_pkg::ZONE_BITS-1:0]        hold_zone,
    input  logic [phlm_pkg::OVER_BITS-1:0]        over_count,
    input  logic                                  cfg_ready
);

    // A waiting word that is not taken stays on the ports unchanged.
    a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_channel) && $stable(peak_segments)
                              && $stable(over_count)))
        else $error("waiting result word changed before it was taken");

    // Zones carry only the three defined codes.
    a_zone_codes: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((peak_zone != 2'd3) && (hold_zone != 2'd3)))
        else $error("undefined zone code on result");

    // Register writes are never back-pressured.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind peak_hold_level_meter phlm_checker u_phlm_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .empty         (empty),
    .pop           (pop),
    .out_channel   (out_channel),
    .peak_segments (peak_segments),
    .peak_zone     (peak_zone),
    .hold_zone     (hold_zone),
    .over_count    (over_count),
    .cfg_ready     (cfg_ready)
);

// ===== tb/peak_hold_level_meter_tb.sv =====
module peak_hold_level_meter_tb;

    import phlm_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int LONG_HOLD_CYCLES = 60;

    typedef struct packed {
        logic [CH_BITS-1:0]    ch;
        logic [LEVEL_BITS-1:0] peak;
        logic [LEVEL_BITS-1:0] rms;
    } level_word_t;

    typedef enum int {SEQ_NOISE, SEQ_CLIP_RUN, SEQ_RISE_DECAY} seq_kind_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      push = 1'b0;
    logic                      full;
    logic [CH_BITS-1:0]        channel = '0;
    logic [LEVEL_BITS-1:0]     peak_level = '0;
    logic [LEVEL_BITS-1:0]     rms_level = '0;
    logic                      empty;
    logic                      pop = 1'b0;
    logic [CH_BITS-1:0]        out_channel;
    logic [WIDTH_BITS-1:0]     peak_segments;
    logic [WIDTH_BITS-1:0]     rms_segments;
    logic [WIDTH_BITS-1:0]     hold_position;
    logic [ZONE_BITS-1:0]      peak_zone;
    logic [ZONE_BITS-1:0]      hold_zone;
    logic                      clip_flag;
    logic [OVER_BITS-1:0]      over_count;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_BITS-1:0]   cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

    // Shadow of the register file and the per-channel meter state.
    cfg_t                      meter_cfg;
    logic [WIDTH_BITS-1:0]     hold_left [CHANNELS];
    logic [CLIP_BITS-1:0]      clip_left [CHANNELS];
    logic [LEVEL_BITS-1:0]     held_peak [CHANNELS];
    logic [WIDTH_BITS-1:0]     clip_run [CHANNELS];
    logic [OVER_BITS-1:0]      over_total [CHANNELS];

    level_word_t               pending_levels [$];
    res_t                      expected_meters [$];
    level_word_t               next_word;

    bit                        word_taken = 1'b0;
    bit                        quiet = 1'b0;
    int                        tx_gap = 0;
    int                        rx_gap = 0;
    int                        rx_long_left = 0;
    int                        rx_long_reqs = 0;
    int                        rx_long_served = 0;
    int                        stall_cycles = 0;
    int                        mismatches = 0;

    peak_hold_level_meter i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .channel       (channel),
        .peak_level    (peak_level),
        .rms_level     (rms_level),
        .empty         (empty),
        .pop           (pop),
        .out_channel   (out_channel),
        .peak_segments (peak_segments),
        .rms_segments  (rms_segments),
        .hold_position (hold_position),
        .peak_zone     (peak_zone),
        .hold_zone     (hold_zone),
        .clip_flag     (clip_flag),
        .over_count    (over_count),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [WIDTH_BITS-1:0] bar_segments(input logic [LEVEL_BITS-1:0] level);
        logic [23:0] seg;
        seg = 24'(meter_cfg.meter_width) * 24'(level);
        seg = seg >> (LEVEL_BITS - 1);
        if (seg > 24'(meter_cfg.meter_width))
        begin
            seg = 24'(meter_cfg.meter_width);
        end
        return seg[WIDTH_BITS-1:0];
    endfunction

    function automatic logic [ZONE_BITS-1:0] level_zone(input logic [LEVEL_BITS-1:0] level);
        if (level >= meter_cfg.red_level)
        begin
            return ZONE_RED;
        end
        if (level >= meter_cfg.amber_level)
        begin
            return ZONE_AMBER;
        end
        return ZONE_NORMAL;
    endfunction

    // Updates one channel's state for an accepted word and returns its meter reading.
    function automatic res_t advance_meter(input logic [CH_BITS-1:0] ch,
                                           input logic [LEVEL_BITS-1:0] pk,
                                           input logic [LEVEL_BITS-1:0] rm);
        res_t        r;
        logic [23:0] mark;
        if (pk[LEVEL_BITS-1])
        begin
            if (clip_run[ch] != '1)
            begin
                clip_run[ch] = clip_run[ch] + 1'b1;
            end
            clip_left[ch] = {meter_cfg.hold_ticks, 1'b0};
            if (clip_run[ch] >= meter_cfg.over_run && over_total[ch] != '1)
            begin
                over_total[ch] = over_total[ch] + 1'b1;
            end
        end
        else
        begin
            clip_run[ch] = '0;
        end
        if (held_peak[ch] < pk)
        begin
            held_peak[ch] = pk;
            hold_left[ch] = meter_cfg.hold_ticks;
        end

        // The hold marker sits two segments below the bar end of the held peak.
        mark = 24'(meter_cfg.meter_width) * 24'(held_peak[ch]);
        mark = mark >> (LEVEL_BITS - 1);
        mark = (mark < 24'd2) ? '0 : mark - 24'd2;
        if (mark > 24'(meter_cfg.meter_width))
        begin
            mark = 24'(meter_cfg.meter_width);
        end

        r.chan      = ch;
        r.peak_seg  = bar_segments(pk);
        r.rms_seg   = bar_segments(rm);
        r.hold_pos  = mark[WIDTH_BITS-1:0];
        r.peak_zone = level_zone(pk);
        r.hold_zone = level_zone(held_peak[ch]);
        r.clip_flag = (clip_left[ch] != '0);
        r.over      = over_total[ch];

        if (hold_left[ch] != '0)
        begin
            hold_left[ch] = hold_left[ch] - 1'b1;
        end
        else if (held_peak[ch] >= meter_cfg.decay_step)
        begin
            held_peak[ch] = held_peak[ch] - meter_cfg.decay_step;
        end
        else
        begin
            held_peak[ch] = '0;
        end
        if (clip_left[ch] != '0)
        begin
            clip_left[ch] = clip_left[ch] - 1'b1;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("mismatch at %0t: %s got %0d want %0d", $realtime, field, got, want);
        mismatches++;
    endtask

    task automatic check_meter();
        res_t want;
        if (expected_meters.size() == 0)
        begin
            report_mismatch("word with none expected, channel", out_channel, 0);
            return;
        end
        want = expected_meters.pop_front();
        if (out_channel !== want.chan)
            report_mismatch("out_channel", out_channel, want.chan);
        if (peak_segments !== want.peak_seg)
            report_mismatch("peak_segments", peak_segments, want.peak_seg);
        if (rms_segments !== want.rms_seg)
            report_mismatch("rms_segments", rms_segments, want.rms_seg);
        if (hold_position !== want.hold_pos)
            report_mismatch("hold_position", hold_position, want.hold_pos);
        if (peak_zone !== want.peak_zone)
            report_mismatch("peak_zone", peak_zone, want.peak_zone);
        if (hold_zone !== want.hold_zone)
            report_mismatch("hold_zone", hold_zone, want.hold_zone);
        if (clip_flag !== want.clip_flag)
            report_mismatch("clip_flag", clip_flag, want.clip_flag);
        if (over_count !== want.over)
            report_mismatch("over_count", over_count, want.over);
    endtask

    // Sender: holds a word until it is taken, with random gaps between words.
    always @(negedge clk)
    begin
        if (rst_n && (!push || word_taken))
        begin
            if (tx_gap > 0)
            begin
                tx_gap--;
                push <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                tx_gap = $urandom_range(0, 12);
                push <= 1'b0;
            end
            else if (pending_levels.size() != 0)
            begin
                next_word = pending_levels.pop_front();
                channel    <= next_word.ch;
                peak_level <= next_word.peak;
                rms_level  <= next_word.rms;
                push       <= 1'b1;
            end
            else
            begin
                push <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else if (rx_long_left > 0)
        begin
            rx_long_left--;
            pop <= 1'b0;
        end
        else if (rx_long_reqs != rx_long_served)
        begin
            rx_long_served++;
            rx_long_left = LONG_HOLD_CYCLES;
            pop <= 1'b0;
        end
        else if (rx_gap > 0)
        begin
            rx_gap--;
            pop <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 9) == 0)
        begin
            rx_gap = $urandom_range(0, 12);
            pop <= 1'b0;
        end
        else
        begin
            pop <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        word_taken = push && !full;
        if (rst_n)
        begin
            if (word_taken)
            begin
                expected_meters.push_back(advance_meter(channel, peak_level, rms_level));
            end
            if (pop && !empty)
            begin
                check_meter();
            end
            if (word_taken || (pop && !empty) || (cfg_valid && cfg_ready))
            begin
                stall_cycles = 0;
            end
            else
            begin
                stall_cycles++;
            end
        end
    end

    initial
    begin
        wait (rst_n);
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
        end
        $display("[peak_hold_level_meter] ERROR");
        $finish;
    end

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_METER_WIDTH: meter_cfg.meter_width = val[WIDTH_BITS-1:0];
            REG_AMBER_LEVEL: meter_cfg.amber_level = val;
            REG_RED_LEVEL:   meter_cfg.red_level   = val;
            REG_HOLD_TICKS:  meter_cfg.hold_ticks  = val[WIDTH_BITS-1:0];
            REG_DECAY_STEP:  meter_cfg.decay_step  = val;
            REG_OVER_RUN:    meter_cfg.over_run    = val[WIDTH_BITS-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_meter(input int width, input int amber, input int red,
                             input int hold, input int decay, input int run);
        write_reg(REG_METER_WIDTH, CFG_DATA_BITS'(width));
        write_reg(REG_AMBER_LEVEL, CFG_DATA_BITS'(amber));
        write_reg(REG_RED_LEVEL, CFG_DATA_BITS'(red));
        write_reg(REG_HOLD_TICKS, CFG_DATA_BITS'(hold));
        write_reg(REG_DECAY_STEP, CFG_DATA_BITS'(decay));
        write_reg(REG_OVER_RUN, CFG_DATA_BITS'(run));
    endtask

    task automatic set_random_meter();
        int amber;
        amber = $urandom_range(8000, 30000);
        set_meter($urandom_range(1, 255), amber, amber + $urandom_range(0, 8000),
                  $urandom_range(0, 40), $urandom_range(0, 3000), $urandom_range(1, 4));
    endtask

    // Returns once the sender has nothing left and every reading has come back.
    task automatic wait_drained();
        while (pending_levels.size() != 0 || push || expected_meters.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (6) @(posedge clk);
    endtask

    task automatic add_word(input logic [CH_BITS-1:0] ch, input logic [LEVEL_BITS-1:0] pk,
                            input logic [LEVEL_BITS-1:0] rm);
        level_word_t w;
        w.ch   = ch;
        w.peak = pk;
        w.rms  = rm;
        pending_levels.push_back(w);
    endtask

    // Mostly clip runs and peak/decay sequences on one channel, some plain noise.
    task automatic add_random_words(input int count);
        int                 n;
        int                 len;
        seq_kind_t          kind;
        logic [CH_BITS-1:0] ch;
        n = 0;
        while (n < count)
        begin
            case ($urandom_range(0, 9))
                0, 1:    kind = SEQ_NOISE;
                2, 3, 4: kind = SEQ_CLIP_RUN;
                default: kind = SEQ_RISE_DECAY;
            endcase
            ch = CH_BITS'($urandom_range(0, CHANNELS - 1));
            case (kind)
                SEQ_NOISE:
                begin
                    add_word(ch, LEVEL_BITS'($urandom), LEVEL_BITS'($urandom));
                    n++;
                end
                SEQ_CLIP_RUN:
                begin
                    len = $urandom_range(1, 6);
                    for (int i = 0; i < len; i++)
                    begin
                        add_word(ch, LEVEL_BITS'($urandom_range(32768, 65535)),
                                 LEVEL_BITS'($urandom));
                    end
                    add_word(ch, LEVEL_BITS'($urandom_range(0, 32767)),
                             LEVEL_BITS'($urandom_range(0, 32767)));
                    n += len + 1;
                end
                default:
                begin
                    len = $urandom_range(4, 30);
                    add_word(ch, LEVEL_BITS'($urandom_range(16384, 40000)),
                             LEVEL_BITS'($urandom_range(0, 32767)));
                    for (int i = 0; i < len; i++)
                    begin
                        add_word(ch, LEVEL_BITS'($urandom_range(0, 4000)),
                                 LEVEL_BITS'($urandom_range(0, 4000)));
                    end
                    n += len + 1;
                end
            endcase
        end
    endtask

    initial
    begin
        meter_cfg.meter_width = 8'd38;
        meter_cfg.amber_level = 16'd21955;
        meter_cfg.red_level   = 16'd25887;
        meter_cfg.hold_ticks  = 8'd24;
        meter_cfg.decay_step  = 16'd655;
        meter_cfg.over_run    = 8'd3;
        for (int c = 0; c < CHANNELS; c++)
        begin
            hold_left[c]  = '0;
            clip_left[c]  = '0;
            held_peak[c]  = '0;
            clip_run[c]   = '0;
            over_total[c] = '0;
        end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed words under the reset settings: scale ends, zone edges, clip runs.
        add_word(3'd0, 16'd0, 16'd0);
        add_word(3'd7, 16'hFFFF, 16'hFFFF);
        add_word(3'd1, 16'd32767, 16'd32768);
        add_word(3'd1, 16'd32768, 16'd1);
        add_word(3'd2, 16'd21954, 16'd21955);
        add_word(3'd2, 16'd21955, 16'd0);
        add_word(3'd2, 16'd25886, 16'd25887);
        add_word(3'd2, 16'd25887, 16'd100);
        add_word(3'd3, 16'd32768, 16'd0);
        add_word(3'd3, 16'd40000, 16'd0);
        add_word(3'd3, 16'd50000, 16'd0);
        add_word(3'd3, 16'hFFFF, 16'd0);
        add_word(3'd3, 16'd32768, 16'd0);
        add_word(3'd3, 16'd100, 16'd0);
        add_word(3'd3, 16'd32768, 16'd0);
        add_word(3'd4, 16'd30000, 16'd5000);
        add_word(3'd4, 16'd10000, 16'd5000);
        add_word(3'd6, 16'd1, 16'd65534);
        add_word(3'd5, 16'd16384, 16'd16384);
        add_word(3'd0, 16'hFFFF, 16'd0);
        wait_drained();

        // Widest bar, every level amber, red only at the top, no hold, full decay.
        set_meter(255, 0, 65535, 0, 65535, 1);
        add_random_words(20);
        wait_drained();

        // Zero-width bar, red everywhere, longest hold, no decay, every clip an over.
        set_meter(0, 65535, 0, 255, 0, 0);
        rx_long_reqs++;
        add_random_words(20);
        wait_drained();

        // One-segment bar, red below amber, and a clip run long enough to saturate.
        set_meter(1, 40000, 30000, 3, 1000, 255);
        for (int i = 0; i < 260; i++)
        begin
            add_word(3'd5, LEVEL_BITS'($urandom_range(32768, 65535)), LEVEL_BITS'($urandom));
            if (i % 16 == 15)
            begin
                add_word(3'd6, LEVEL_BITS'($urandom), LEVEL_BITS'($urandom));
            end
        end
        wait_drained();

        for (int p = 0; p < 3; p++)
        begin
            set_random_meter();
            if (p == 1)
            begin
                rx_long_reqs++;
            end
            add_random_words(10);
            wait_drained();
        end

        quiet = 1'b1;
        set_meter(38, 21955, 25887, 24, 655, 3);
        add_random_words(15);
        wait_drained();

        if (mismatches == 0)
        begin
            $display("[peak_hold_level_meter] OK");
        end
        else
        begin
            $display("[peak_hold_level_meter] ERROR");
        end
        $finish;
    end

endmodule
